// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the quaternion to euler block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define QTE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every edge, reset included
`define QTE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg
// shared types, constants and tables of the quaternion to euler block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;
   localparam int CORDIC_STEPS = 16;
   localparam int LAT_C        = CORDIC_STEPS + 1;
   localparam int TW           = 35;
   localparam int CW           = 38;
   localparam int THR_W        = 15;
   // low part width of the split gain multiply and the product sum width
   localparam int SPLIT        = 19;
   localparam int PW           = CW + 25;
   localparam logic signed [TW-1:0] ONE_Q30 = TW'(2**30);
   localparam logic [23:0] INV_GAIN = 24'd10188014;
   localparam logic [31:0] QUARTER  = 32'h4000_0000;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } req_type;

   typedef struct packed {
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic               gimbal_lock;
   } rsp_type;

   typedef struct packed {
      logic signed [TW-1:0] m31;
      logic signed [TW-1:0] m32;
      logic signed [TW-1:0] m33;
      logic signed [TW-1:0] m12;
      logic signed [TW-1:0] m22;
      logic signed [TW-1:0] m11;
      logic signed [TW-1:0] m21;
   } terms_type;

   // arctangent of 2^-i as a 32-bit binary angle
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // round a 32-bit binary angle to 16 bits
   function automatic logic signed [15:0] to_angle16(input logic [31:0] acc);
      logic [31:0] s;
      s = acc + 32'h0000_8000;
      return s[31:16];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/qte_front.sv -----
// ----------------------------------------------------------------------------
// qte_front
// input register, quaternion products and rotation matrix terms
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qte_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire qte_pkg::req_type   in_word,
   input  wire logic               advance,
   output logic                    out_valid,
   output qte_pkg::terms_type      out_terms
);
   import qte_pkg::*;

   logic v0_ff, v1_ff, v2_ff;
   req_type q_ff;
   logic signed [31:0] xx_ff, yy_ff, zz_ff, xz_ff, yw_ff, yz_ff, xw_ff, xy_ff, zw_ff;
   terms_type t_ff, t_in;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   // input capture, products and matrix terms
   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff  <= in_word;
         xx_ff <= q_ff.quat_x * q_ff.quat_x;
         yy_ff <= q_ff.quat_y * q_ff.quat_y;
         zz_ff <= q_ff.quat_z * q_ff.quat_z;
         xz_ff <= q_ff.quat_x * q_ff.quat_z;
         yw_ff <= q_ff.quat_y * q_ff.quat_w;
         yz_ff <= q_ff.quat_y * q_ff.quat_z;
         xw_ff <= q_ff.quat_x * q_ff.quat_w;
         xy_ff <= q_ff.quat_x * q_ff.quat_y;
         zw_ff <= q_ff.quat_z * q_ff.quat_w;
         t_ff  <= t_in;
      end
   end

   // matrix terms, exact with 30 fraction bits
   always_comb begin
      t_in.m31 = (TW'(xz_ff) + TW'(yw_ff)) <<< 1;
      t_in.m32 = (TW'(yz_ff) - TW'(xw_ff)) <<< 1;
      t_in.m33 = ONE_Q30 - ((TW'(xx_ff) + TW'(yy_ff)) <<< 1);
      t_in.m12 = (TW'(xy_ff) + TW'(zw_ff)) <<< 1;
      t_in.m22 = ONE_Q30 - ((TW'(xx_ff) + TW'(zz_ff)) <<< 1);
      t_in.m11 = ONE_Q30 - ((TW'(yy_ff) + TW'(zz_ff)) <<< 1);
      t_in.m21 = (TW'(xy_ff) - TW'(zw_ff)) <<< 1;
   end

   assign out_valid = v2_ff;
   assign out_terms = t_ff;
endmodule
`default_nettype wire

// ----- rtl/qte_queue.sv -----
// ----------------------------------------------------------------------------
// qte_queue
// four-entry queue of matrix terms between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qte_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire qte_pkg::terms_type push_word,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output qte_pkg::terms_type      pop_word
);
   import qte_pkg::*;

   terms_type  slot_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic       do_push, do_pop;

   assign full    = cnt_ff == 3'd4;
   assign empty   = cnt_ff == 3'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 2'd0;
         rp_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         if (do_push) wp_ff <= wp_ff + 2'd1;
         if (do_pop)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(do_push) - 3'(do_pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wp_ff] <= push_word;
   end

   assign pop_word = slot_ff[rp_ff];
endmodule
`default_nettype wire

// ----- rtl/qte_cordic.sv -----
// ----------------------------------------------------------------------------
// qte_cordic
// pipelined vectoring cordic, one rotation step per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic (
   input  wire logic                            clock,
   input  wire logic                            advance,
   input  wire logic signed [qte_pkg::CW-1:0]   in_x,
   input  wire logic signed [qte_pkg::CW-1:0]   in_y,
   output logic signed [qte_pkg::CW-1:0]        out_mag,
   output logic [31:0]                          out_angle
);
   import qte_pkg::*;

   logic signed [CW-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] y_ff [CORDIC_STEPS+1];
   logic [31:0]          z_ff [CORDIC_STEPS+1];
   logic                 zero_ff [CORDIC_STEPS+1];

   // quadrant fold into the right half plane
   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
         if (in_x < 0) begin
            if (in_y >= 0) begin
               x_ff[0] <= in_y;
               y_ff[0] <= -in_x;
               z_ff[0] <= QUARTER;
            end else begin
               x_ff[0] <= -in_y;
               y_ff[0] <= in_x;
               z_ff[0] <= 32'd0 - QUARTER;
            end
         end else begin
            x_ff[0] <= in_x;
            y_ff[0] <= in_y;
            z_ff[0] <= 32'd0;
         end
      end
   end

   // rotation steps
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] < 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(5'(i));
            end
         end
      end
   end

   // zero vector gives angle zero
   assign out_mag   = x_ff[CORDIC_STEPS];
   assign out_angle = zero_ff[CORDIC_STEPS] ? 32'd0 : z_ff[CORDIC_STEPS];
endmodule
`default_nettype wire

// ----- rtl/qte_back.sv -----
// ----------------------------------------------------------------------------
// qte_back
// cordic angles, cy scaling, gimbal branch and two-word result buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qte_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire qte_pkg::terms_type        in_terms,
   output logic                           in_take,
   input  wire logic [qte_pkg::THR_W-1:0] threshold,
   output logic                           out_valid,
   output qte_pkg::rsp_type               out_word,
   input  wire logic                      out_pop
);
   import qte_pkg::*;

   typedef struct packed {
      logic [31:0] ay;
      logic [31:0] az;
      logic        lock;
   } side_type;

   logic advance;
   logic [1:0] cnt_ff;
   logic va_ff [LAT_C];
   logic vd_ff [LAT_C];
   logic v1_ff, v2_ff;
   logic signed [TW-1:0] m32_ff [LAT_C];
   logic signed [CW-1:0] mag_a;
   logic [31:0] ang_a, ang_b, ang_c, ang_d;
   logic signed [CW-1:0] unused_b, unused_c, unused_d;
   logic [31:0] ay1_ff, azn1_ff, azl1_ff;
   logic signed [TW-1:0] m32_1_ff;
   logic [SPLIT+23:0] plo_ff;
   logic signed [CW-SPLIT+24:0] phi_ff;
   logic signed [PW-1:0] sum;
   logic signed [CW-1:0] cy, thr_q, cy_ff, nm32_ff;
   side_type side2_ff;
   side_type sided_ff [LAT_C];
   rsp_type buf_ff [2];
   rsp_type res;
   logic wp_ff, rp_ff;
   logic push, pop;

   // back advances while the result buffer has room
   assign advance = cnt_ff != 2'd2;
   assign in_take = advance && in_valid;

   // three angles from the terms
   qte_cordic u_cord_a (.clock, .advance, .in_x(CW'(in_terms.m33)),
      .in_y(CW'(in_terms.m31)), .out_mag(mag_a), .out_angle(ang_a));
   qte_cordic u_cord_b (.clock, .advance, .in_x(CW'(in_terms.m22)),
      .in_y(CW'(in_terms.m12)), .out_mag(unused_b), .out_angle(ang_b));
   qte_cordic u_cord_c (.clock, .advance, .in_x(CW'(in_terms.m11)),
      .in_y(-CW'(in_terms.m21)), .out_mag(unused_c), .out_angle(ang_c));

   // valid delay across both cordics and the scaling stages between them
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT_C; i++) begin
            va_ff[i] <= 1'b0;
            vd_ff[i] <= 1'b0;
         end
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         va_ff[0] <= in_take;
         for (int i = 1; i < LAT_C; i++) va_ff[i] <= va_ff[i-1];
         v1_ff <= va_ff[LAT_C-1];
         v2_ff <= v1_ff;
         vd_ff[0] <= v2_ff;
         for (int i = 1; i < LAT_C; i++) vd_ff[i] <= vd_ff[i-1];
      end
   end

   // cy scaling by the inverse cordic gain, two partial products
   assign sum = (PW'(phi_ff) <<< SPLIT) + PW'($signed({1'b0, plo_ff})) + PW'(2**23);
   assign cy = CW'(sum >>> 24);
   assign thr_q = {(CW-30)'(0), threshold, 15'd0};

   always_ff @(posedge clock) begin
      if (advance) begin
         m32_ff[0] <= in_terms.m32;
         for (int i = 1; i < LAT_C; i++) m32_ff[i] <= m32_ff[i-1];
         plo_ff   <= mag_a[SPLIT-1:0] * INV_GAIN;
         phi_ff   <= mag_a[CW-1:SPLIT] * $signed({1'b0, INV_GAIN});
         ay1_ff   <= ang_a;
         azn1_ff  <= ang_b;
         azl1_ff  <= ang_c;
         m32_1_ff <= m32_ff[LAT_C-1];
         cy_ff    <= cy;
         nm32_ff  <= -CW'(m32_1_ff);
         side2_ff.ay   <= ay1_ff;
         side2_ff.lock <= !(cy > thr_q);
         side2_ff.az   <= (cy > thr_q) ? azn1_ff : azl1_ff;
         sided_ff[0] <= side2_ff;
         for (int i = 1; i < LAT_C; i++) sided_ff[i] <= sided_ff[i-1];
      end
   end

   // angle about x from cy and m32
   qte_cordic u_cord_d (.clock, .advance, .in_x(cy_ff), .in_y(nm32_ff),
      .out_mag(unused_d), .out_angle(ang_d));

   // result formatting
   always_comb begin
      res.angle_x     = to_angle16(ang_d);
      res.angle_y     = sided_ff[LAT_C-1].lock ? 16'sd0 : to_angle16(sided_ff[LAT_C-1].ay);
      res.angle_z     = to_angle16(sided_ff[LAT_C-1].az);
      res.gimbal_lock = sided_ff[LAT_C-1].lock;
   end

   // two-word result buffer
   assign push = advance && vd_ff[LAT_C-1];
   assign pop  = out_pop && (cnt_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) buf_ff[wp_ff] <= res;
   end

   assign out_valid = cnt_ff != 2'd0;
   assign out_word  = buf_ff[rp_ff];
endmodule
`default_nettype wire

// ----- rtl/quaternion_to_euler.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler
// unit quaternion in Q1.15 to three 16-bit binary euler angles
// ----------------------------------------------------------------------------
// The block takes one quaternion word per clock while req_full is low and
// returns one angle word per quaternion, in order. A word passes three front
// stages (capture, products, matrix terms), a four-word queue, two chained
// cordic pipelines of CORDIC_STEPS + 1 stages each with two scaling stages
// between them, and a two-word result buffer. The rate is one word per
// cycle, set by the fully pipelined cordic stages; the front stalls only on
// a full queue and the back only on a full result buffer. The user must write
// the gimbal threshold through csr_we / csr_wdata only while no word is in
// flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module quaternion_to_euler (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   input  wire qte_pkg::req_type          req_word,
   output logic                           req_full,
   output logic                           rsp_empty,
   output qte_pkg::rsp_type               rsp_word,
   input  wire logic                      rsp_pop,
   input  wire logic                      csr_we,
   input  wire logic [qte_pkg::THR_W-1:0] csr_wdata
);
   import qte_pkg::*;

   logic [THR_W-1:0] thr_ff;
   logic q_full, q_empty, q_pop, f_valid, b_valid;
   terms_type f_terms, q_terms;

   // gimbal threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign req_full = q_full;

   qte_front u_front (.clock, .reset, .in_valid(req_push && !req_full),
      .in_word(req_word), .advance(!q_full), .out_valid(f_valid), .out_terms(f_terms));

   qte_queue u_queue (.clock, .reset, .push(f_valid && !q_full), .push_word(f_terms),
      .full(q_full), .pop(q_pop), .empty(q_empty), .pop_word(q_terms));

   qte_back u_back (.clock, .reset, .in_valid(!q_empty), .in_terms(q_terms),
      .in_take(q_pop), .threshold(thr_ff), .out_valid(b_valid), .out_word(rsp_word),
      .out_pop(rsp_pop));

   assign rsp_empty = !b_valid;

   // checks
   `QTE_ASSERT(a_lock_zero_y, (!rsp_empty && rsp_word.gimbal_lock) |-> (rsp_word.angle_y == 16'sd0), "angle_y not zero at gimbal lock")
   `QTE_ASSERT(a_full_hold, (req_full && !q_pop) |=> req_full, "queue full dropped without a pop")
   `QTE_ASSERT_ALWAYS(a_reset_empty, reset |=> rsp_empty, "result present right after reset")
endmodule
`default_nettype wire

// ----- tb/quaternion_to_euler_test.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_test
// self-checking bench for the quaternion to euler block
// ----------------------------------------------------------------------------
// Quaternion words are pushed through the queue-style input. Each accepted
// word is run through a bit-exact cordic predictor, and the expected angle
// word is queued. A monitor compares every popped word field by field.
// Threshold writes happen only while the block is drained.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_test;
   import qte_pkg::*;

   localparam int NSTEPS    = CORDIC_STEPS;
   localparam int LATENCY   = 2 * NSTEPS + 12;
   localparam int WDOG_MAX  = 20000;

   logic clock;
   logic reset;
   logic req_push;
   req_type req_word;
   logic req_full;
   logic rsp_empty;
   rsp_type rsp_word;
   logic rsp_pop;
   logic csr_we;
   logic [THR_W-1:0] csr_wdata;

   rsp_type angles_pending[$];
   logic [THR_W-1:0] lock_thresh;
   int errors;
   int idle_pct;
   int hold_cycles;
   int stall_count;

   quaternion_to_euler u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_word(req_word), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_word(rsp_word), .rsp_pop(rsp_pop),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // atan of 2^-i as 32-bit binary angle
   function automatic logic [31:0] atan_step(input int i);
      logic [31:0] tbl [0:23];
      tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
              32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      return tbl[i];
   endfunction

   // vectoring cordic: angle of (vx, vy), scaled magnitude in mag
   function automatic logic [31:0] vector_angle(input longint vx, input longint vy,
                                                output longint mag);
      logic [31:0] acc;
      longint xs, ys, t;
      acc = 32'h0;
      mag = 0;
      if (vx == 0 && vy == 0) return 32'h0;
      if (vx < 0) begin
         t = vx;
         if (vy >= 0) begin
            vx = vy; vy = -t; acc = QUARTER;
         end else begin
            vx = -vy; vy = t; acc = 32'h0 - QUARTER;
         end
      end
      for (int i = 0; i < NSTEPS; i++) begin
         xs = vx >>> i;
         ys = vy >>> i;
         if (vy < 0) begin
            vx = vx - ys; vy = vy + xs; acc = acc - atan_step(i);
         end else begin
            vx = vx + ys; vy = vy - xs; acc = acc + atan_step(i);
         end
      end
      mag = (vx * longint'(10188014) + (longint'(1) << 23)) >>> 24;
      return acc;
   endfunction

   function automatic logic [15:0] round_angle(input logic [31:0] acc);
      logic [31:0] s;
      s = acc + 32'h8000;
      return s[31:16];
   endfunction

   // expected euler angles for one quaternion
   function automatic rsp_type euler_of(input req_type q, input logic [THR_W-1:0] thr);
      longint x, y, z, w, xx, yy, zz, m31, m32, m33, m12, m22, m11, m21, cy, dummy;
      logic [31:0] ax, ay, az;
      rsp_type r;
      x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
      xx = x * x; yy = y * y; zz = z * z;
      m31 = 2 * (x * z + y * w);
      m32 = 2 * (y * z - x * w);
      m33 = (longint'(1) << 30) - 2 * (xx + yy);
      ay = vector_angle(m33, m31, cy);
      ax = vector_angle(cy, -m32, dummy);
      r.gimbal_lock = !(cy > (longint'(thr) << 15));
      if (!r.gimbal_lock) begin
         m12 = 2 * (x * y + z * w);
         m22 = (longint'(1) << 30) - 2 * (xx + zz);
         az = vector_angle(m22, m12, dummy);
         r.angle_y = round_angle(ay);
      end else begin
         m11 = (longint'(1) << 30) - 2 * (yy + zz);
         m21 = 2 * (x * y - z * w);
         az = vector_angle(m11, -m21, dummy);
         r.angle_y = '0;
      end
      r.angle_x = round_angle(ax);
      r.angle_z = round_angle(az);
      return r;
   endfunction

   // push one quaternion word, predict at acceptance; push stays high after
   task automatic send_quat(input req_type q);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_word <= q;
      @(posedge clock);
      while (req_full) @(posedge clock);
      angles_pending.push_back(euler_of(q, lock_thresh));
      @(negedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (angles_pending.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_thresh(input logic [THR_W-1:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      lock_thresh = v;
   endtask

   function automatic req_type random_quat();
      req_type q;
      int k;
      real a, b, c, d, n;
      k = $urandom_range(9);
      if (k < 3) begin
         q = req_type'({$urandom, $urandom});
      end else if (k < 5) begin
         // w at +-23170, x spread, y and z small: pitch stays near zero
         q.quat_x = 16'(int'($urandom_range(23170) - 11585));
         q.quat_w = ($urandom_range(1)) ? 16'(23170) : -16'(23170);
         q.quat_y = 16'(int'($urandom_range(64)) - 32);
         q.quat_z = 16'(int'($urandom_range(64)) - 32);
      end else begin
         a = real'(int'($urandom_range(2000)) - 1000);
         b = real'(int'($urandom_range(2000)) - 1000);
         c = real'(int'($urandom_range(2000)) - 1000);
         d = real'(int'($urandom_range(2000)) - 1000) + 0.5;
         n = $sqrt(a * a + b * b + c * c + d * d);
         q.quat_x = 16'(int'(a / n * 32767.0));
         q.quat_y = 16'(int'(b / n * 32767.0));
         q.quat_z = 16'(int'(c / n * 32767.0));
         q.quat_w = 16'(int'(d / n * 32767.0));
      end
      return q;
   endfunction

   // directed corners: identity, zeros, extremes, pitch at +-pi/2, pi wrap
   task automatic test_corners();
      logic signed [15:0] v [6] = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh5A82,
                                    -16'sh5A82, 16'sh0001};
      send_quat('{16'sh0, 16'sh0, 16'sh0, 16'sh7FFF});
      send_quat('{16'sh0, 16'sh0, 16'sh0, 16'sh0});
      send_quat('{16'sh7FFF, 16'sh0, 16'sh0, 16'sh0});
      send_quat('{16'sh0, 16'sh7FFF, 16'sh0, 16'sh0});
      send_quat('{16'sh0, 16'sh0, 16'sh7FFF, 16'sh0});
      send_quat('{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000});
      send_quat('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
      send_quat('{16'sh5A82, 16'sh0, 16'sh0, 16'sh5A82});
      send_quat('{-16'sh5A82, 16'sh0, 16'sh0, 16'sh5A82});
      send_quat('{16'sh0, 16'sh5A82, 16'sh0, 16'sh5A82});
      send_quat('{16'sh0, -16'sh0001, 16'sh0, 16'sh7FFF});
      for (int i = 0; i < 12; i++)
         send_quat('{v[i % 6], v[(i + 1) % 6], v[(i + 3) % 6], v[(i + 5) % 6]});
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) send_quat(random_quat());
   endtask

   task automatic test_thresholds();
      logic [THR_W-1:0] th [4] = '{15'd0, 15'h7FFF, 15'd400, 15'd3000};
      foreach (th[i]) begin
         write_thresh(th[i]);
         test_corners();
         test_random(250);
      end
      write_thresh(15'd1);
   endtask

   // fill the block while the receiver holds off
   task automatic test_backpressure();
      drain();
      idle_pct = 0;
      hold_cycles = 300;
      test_random(120);
      idle_pct = 31;
   endtask

   // result checker and pop driver
   initial begin
      rsp_type exp_w;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (angles_pending.size() == 0) begin
               $error("unexpected word %h", rsp_word);
               errors++;
            end else begin
               exp_w = angles_pending.pop_front();
               if (rsp_word.angle_x !== exp_w.angle_x) begin
                  $error("angle_x exp %0d got %0d", exp_w.angle_x, rsp_word.angle_x);
                  errors++;
               end
               if (rsp_word.angle_y !== exp_w.angle_y) begin
                  $error("angle_y exp %0d got %0d", exp_w.angle_y, rsp_word.angle_y);
                  errors++;
               end
               if (rsp_word.angle_z !== exp_w.angle_z) begin
                  $error("angle_z exp %0d got %0d", exp_w.angle_z, rsp_word.angle_z);
                  errors++;
               end
               if (rsp_word.gimbal_lock !== exp_w.gimbal_lock) begin
                  $error("gimbal_lock exp %0b got %0b", exp_w.gimbal_lock,
                         rsp_word.gimbal_lock);
                  errors++;
               end
            end
         end
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // watchdog on cycles with no accepted or popped word
   initial begin
      stall_count = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset
             || hold_cycles > 0)
            stall_count = 0;
         else
            stall_count++;
         if (stall_count >= WDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // sequence of tests
   initial begin
      errors = 0;
      idle_pct = 31;
      hold_cycles = 0;
      lock_thresh = THR_RESET;
      reset = 1'b1;
      req_push = 1'b0;
      req_word = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_corners();
      test_random(300);
      test_backpressure();
      idle_pct = 0;
      test_random(300);
      idle_pct = 31;
      test_thresholds();
      test_random(100);
      drain();
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
